@@ design/htok_pkg.sv @@
package htok_pkg;

   typedef enum logic [3:0] {
      ST_DATA       = 4'd0,
      ST_TAG_OPEN   = 4'd1,
      ST_TAG_NAME   = 4'd2,
      ST_BEFORE_KEY = 4'd3,
      ST_KEY        = 4'd4,
      ST_BEFORE_VAL = 4'd5,
      ST_VAL_DQ     = 4'd6,
      ST_AFTER_VAL  = 4'd7,
      ST_TEXT       = 4'd8,
      ST_TEXT_SPACE = 4'd9
   } lex_state_type;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_TEXT = 2'd1,
      KIND_TAG  = 2'd2
   } token_kind_type;

   typedef enum logic [1:0] {
      TEND_NONE   = 2'd0,
      TEND_AFTER  = 2'd1,
      TEND_BEFORE = 2'd2
   } token_end_type;

   localparam logic [7:0] CHAR_LT    = 8'h3C;
   localparam logic [7:0] CHAR_GT    = 8'h3E;
   localparam logic [7:0] CHAR_EQ    = 8'h3D;
   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   typedef struct packed {
      logic           append_data;
      logic           append_key;
      logic           append_value;
      logic           key_done;
      logic           value_done;
      token_end_type  token_end;
      token_kind_type token_kind;
      logic [7:0]     byte_out;
   } rsp_type;

   function automatic logic is_printable(input logic [7:0] c);
      return (c >= 8'h21) && (c <= 8'h7E);
   endfunction

endpackage

@@ design/html_char_tokenizer.sv @@
// channel  | valid      | stall      | payload
// ---------+------------+------------+---------------------------------------------
// request  | req_valid  | req_stall  | req_char_in
// response | rsp_valid  | rsp_stall  | rsp_append_data .. rsp_token_kind, rsp_byte_out
//
// One byte per cycle sustained while the response is not stalled.
// The rate is set by the single lexer state update, done once per byte.
// A byte sits in the input register, steps the lexer and lands in the response register.
// While the response stalls, one more byte is still taken into the input register.
// Reset (synchronous, active high) empties both registers and returns the lexer to data.
module html_char_tokenizer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_append_data,
   output logic       rsp_append_key,
   output logic       rsp_append_value,
   output logic       rsp_key_done,
   output logic       rsp_value_done,
   output logic [1:0] rsp_token_end,
   output logic [1:0] rsp_token_kind,
   output logic [7:0] rsp_byte_out
);

   logic                    in_valid_ff;
   logic [7:0]              char_ff;
   logic                    out_valid_ff;
   htok_pkg::rsp_type       rsp_ff;
   htok_pkg::rsp_type       rsp_in;
   htok_pkg::lex_state_type state_ff;
   htok_pkg::lex_state_type state_in;
   htok_pkg::token_kind_type kind_ff;
   htok_pkg::token_kind_type kind_in;
   logic                    close_tag;
   logic                    advance;
   logic                    step;
   logic                    req_fire;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_fire  = req_valid && !req_stall;

   always_comb begin
      logic data;
      logic key;
      logic val;
      logic kdone;
      logic vdone;
      htok_pkg::token_end_type tend;
      data      = 1'b0;
      key       = 1'b0;
      val       = 1'b0;
      kdone     = 1'b0;
      vdone     = 1'b0;
      tend      = htok_pkg::TEND_NONE;
      close_tag = 1'b0;
      state_in  = state_ff;
      kind_in   = kind_ff;
      case (state_ff)
         htok_pkg::ST_TAG_OPEN: begin
            if (htok_pkg::is_printable(char_ff)) begin
               state_in = htok_pkg::ST_TAG_NAME;
               kind_in  = htok_pkg::KIND_TAG;
               data     = 1'b1;
            end
         end
         htok_pkg::ST_TAG_NAME: begin
            if (char_ff == htok_pkg::CHAR_SPACE) begin
               state_in = htok_pkg::ST_BEFORE_KEY;
               data     = 1'b1;
            end else if (char_ff == htok_pkg::CHAR_GT) begin
               data      = 1'b1;
               close_tag = 1'b1;
            end else if (htok_pkg::is_printable(char_ff)) begin
               data = 1'b1;
            end
         end
         htok_pkg::ST_BEFORE_KEY: begin
            // space is accepted here as a name character
            if (char_ff >= htok_pkg::CHAR_SPACE && char_ff <= 8'h7E) begin
               key      = 1'b1;
               data     = 1'b1;
               state_in = htok_pkg::ST_KEY;
            end
         end
         htok_pkg::ST_KEY: begin
            if (char_ff == htok_pkg::CHAR_EQ) begin
               data     = 1'b1;
               kdone    = 1'b1;
               state_in = htok_pkg::ST_BEFORE_VAL;
            end else if (htok_pkg::is_printable(char_ff)) begin
               key  = 1'b1;
               data = 1'b1;
            end
         end
         htok_pkg::ST_BEFORE_VAL: begin
            if (char_ff == htok_pkg::CHAR_QUOTE) begin
               data     = 1'b1;
               state_in = htok_pkg::ST_VAL_DQ;
            end
         end
         htok_pkg::ST_VAL_DQ: begin
            if (char_ff == htok_pkg::CHAR_QUOTE) begin
               vdone    = 1'b1;
               data     = 1'b1;
               state_in = htok_pkg::ST_AFTER_VAL;
            end else if (htok_pkg::is_printable(char_ff)) begin
               val  = 1'b1;
               data = 1'b1;
            end
         end
         htok_pkg::ST_AFTER_VAL: begin
            if (char_ff == htok_pkg::CHAR_GT) begin
               data      = 1'b1;
               close_tag = 1'b1;
            end else if (char_ff == htok_pkg::CHAR_SPACE) begin
               data     = 1'b1;
               state_in = htok_pkg::ST_BEFORE_KEY;
            end
         end
         htok_pkg::ST_TEXT, htok_pkg::ST_TEXT_SPACE: begin
            // '<' ends the text token before it and opens a tag
            if (char_ff == htok_pkg::CHAR_LT) begin
               tend     = htok_pkg::TEND_BEFORE;
               data     = 1'b1;
               kind_in  = htok_pkg::KIND_NONE;
               state_in = htok_pkg::ST_TAG_OPEN;
            end else if (char_ff == htok_pkg::CHAR_SPACE
                         && state_ff == htok_pkg::ST_TEXT) begin
               data     = 1'b1;
               state_in = htok_pkg::ST_TEXT_SPACE;
            end else if (htok_pkg::is_printable(char_ff)) begin
               data = 1'b1;
            end
         end
         default: begin
            if (char_ff == htok_pkg::CHAR_LT) begin
               state_in = htok_pkg::ST_TAG_OPEN;
               kind_in  = htok_pkg::KIND_NONE;
               data     = 1'b1;
            end else if (htok_pkg::is_printable(char_ff)) begin
               state_in = htok_pkg::ST_TEXT;
               kind_in  = htok_pkg::KIND_TEXT;
               data     = 1'b1;
            end
         end
      endcase

      // report the kind of the token just built, then close it
      rsp_in.token_kind = kind_in;
      if (close_tag) begin
         tend     = htok_pkg::TEND_AFTER;
         state_in = htok_pkg::ST_DATA;
         kind_in  = htok_pkg::KIND_NONE;
      end

      rsp_in.append_data  = data;
      rsp_in.append_key   = key;
      rsp_in.append_value = val;
      rsp_in.key_done     = kdone;
      rsp_in.value_done   = vdone;
      rsp_in.token_end    = tend;
      rsp_in.byte_out     = data ? char_ff : 8'h00;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= htok_pkg::ST_DATA;
         kind_ff      <= htok_pkg::KIND_NONE;
      end else begin
         if (req_fire) begin
            in_valid_ff <= 1'b1;
         end else if (step) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         if (step) begin
            state_ff <= state_in;
            kind_ff  <= kind_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         char_ff <= req_char_in;
      end
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_append_data  = rsp_ff.append_data;
   assign rsp_append_key   = rsp_ff.append_key;
   assign rsp_append_value = rsp_ff.append_value;
   assign rsp_key_done     = rsp_ff.key_done;
   assign rsp_value_done   = rsp_ff.value_done;
   assign rsp_token_end    = rsp_ff.token_end;
   assign rsp_token_kind   = rsp_ff.token_kind;
   assign rsp_byte_out     = rsp_ff.byte_out;

   a_close_returns_data: assert property (@(posedge clock) disable iff (reset)
      (step && close_tag) |=> (state_ff == htok_pkg::ST_DATA
                               && kind_ff == htok_pkg::KIND_NONE))
      else $error("tag close did not return lexer to data");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff))
      else $error("request stalled with a free stage");

   a_byte_matches_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_byte_out != 8'h00) == rsp_append_data))
      else $error("byte echo disagrees with append flag");

   a_key_implies_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_append_key || rsp_append_value || rsp_key_done
                     || rsp_value_done)) |-> rsp_append_data)
      else $error("attribute flag without token append");

   a_text_end_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_token_end == htok_pkg::TEND_BEFORE)
      |-> (rsp_token_kind == htok_pkg::KIND_NONE))
      else $error("text end with a live token kind");

   a_state_holds_idle: assert property (@(posedge clock) disable iff (reset)
      !step |=> ($stable(state_ff) && $stable(kind_ff)))
      else $error("lexer moved without a byte");

endmodule
